@@ rtl/core/jls_pkg.sv @@
// Shared types and constants for the Jacobi linear solver.
package jls_pkg;
   localparam int MaxSize = 16;
   localparam int FracBits = 16;
   localparam int IdxW = 4;
   localparam int AddrW = 8;

   typedef enum logic [1:0] {
      ACT_COEF = 2'd0,
      ACT_RHS = 2'd1,
      ACT_SOLVE = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_SIZE = 2'd0,
      CSR_TOL = 2'd1,
      CSR_ITER = 2'd2,
      CSR_NONE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        start;
      logic [32:0] numer;
      logic [31:0] denom;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;
endpackage

@@ rtl/core/jls_ram.sv @@
// Generic single-port-write, registered-read RAM.
module jls_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/core/jls_divider.sv @@
// Restoring divider: saturated signed (numer * 2^16) / denom, one bit per cycle.
module jls_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  jls_pkg::div_req_type req,
   output jls_pkg::div_rsp_type rsp
);
   localparam int DW = 33 + jls_pkg::FracBits;

   logic [DW-1:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [32:0] numer_abs;
   logic [32:0] trial;
   logic [DW-1:0] qs;

   always_comb begin
      numer_abs = req.numer[32] ? (~req.numer + 33'd1) : req.numer;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[31:0], quo_ff[DW-1]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in = {numer_abs, {jls_pkg::FracBits{1'b0}}};
         rem_in = '0;
         den_in = req.denom[31] ? (~req.denom + 32'd1) : req.denom;
         neg_in = req.numer[32] ^ req.denom[31];
         cnt_in = 6'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[DW-1]};
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      qs = neg_ff ? (~quo_ff + DW'(1)) : quo_ff;
      rsp.done = done_ff;
      if (!neg_ff && quo_ff > DW'(32'h7fffffff)) begin
         rsp.quot = 32'h7fffffff;
      end else if (neg_ff && quo_ff > DW'(33'h80000000)) begin
         rsp.quot = 32'h80000000;
      end else begin
         rsp.quot = qs[31:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

@@ rtl/core/jacobi_linear_solver_top.sv @@
// Top level of the Jacobi linear solver with its sweep sequencer.
// Load requests are accepted while the block is idle. A solve runs sweeps over n unknowns; each
// row reads n coefficients through one multiplier and then uses a shared divider (skipped on a
// zero diagonal); each sweep ends with a copy/compare pass, and the solution is then emitted one
// entry per cycle while rsp_ready is high. The block is not ready during a solve.
module jacobi_linear_solver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_row,
   input  logic [3:0]  req_col,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_index,
   output logic signed [31:0] rsp_solution,
   output logic        rsp_last,
   output logic [15:0] rsp_sweeps_done,
   output logic        rsp_converged,
   output logic        rsp_zero_pivot,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_ROW, ST_MAC, ST_DIAG, ST_DIV, ST_CMP, ST_EMIT
   } state_type;

   state_type state_ff;
   logic [4:0] size_ff;
   logic [30:0] tol_ff;
   logic [15:0] iter_ff;
   logic [3:0] i_ff, j_ff, jd_ff;
   logic jv_ff, jvd_ff, jv2_ff;
   logic signed [31:0] xj_ff;
   logic signed [63:0] prod_ff;
   logic signed [51:0] acc_ff;
   logic [15:0] sweeps_ff;
   logic [31:0] change_ff;
   logic pivot_ff, conv_ff;
   logic signed [31:0] est_ff [jls_pkg::MaxSize];
   logic signed [31:0] nxt_ff [jls_pkg::MaxSize];
   logic [3:0] last_idx;
   logic [4:0] n_act;

   logic coef_we, rhs_we;
   logic [7:0] coef_ra;
   logic [31:0] coef_rd, rhs_rd;
   jls_pkg::div_req_type dreq;
   jls_pkg::div_rsp_type drsp;

   logic signed [51:0] acc_next;
   logic signed [31:0] acc_sat;
   logic signed [32:0] numer;
   logic [32:0] diff;
   logic [31:0] adiff;

   assign n_act = (size_ff == 5'd0) ? 5'd1 : (size_ff > 5'd16 ? 5'd16 : size_ff);
   assign last_idx = 4'(n_act - 5'd1);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign coef_we = req_valid && req_ready && req_action == jls_pkg::ACT_COEF;
   assign rhs_we = req_valid && req_ready && req_action == jls_pkg::ACT_RHS;
   assign coef_ra = (state_ff == ST_DIAG || (state_ff == ST_MAC && !jv_ff)) ?
                    {i_ff, i_ff} : {i_ff, j_ff};

   jls_ram #(.Width(32), .Depth(256)) u_coef (
      .clock(clock), .wr_en(coef_we), .wr_addr({req_row, req_col}), .wr_data(req_value),
      .rd_addr(coef_ra), .rd_data(coef_rd));
   jls_ram #(.Width(32), .Depth(16)) u_rhs (
      .clock(clock), .wr_en(rhs_we), .wr_addr(req_row), .wr_data(req_value),
      .rd_addr(i_ff), .rd_data(rhs_rd));
   jls_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      acc_next = acc_ff + 52'(prod_ff >>> jls_pkg::FracBits);
      if (acc_ff > 52'sd2147483647) acc_sat = 32'sh7fffffff;
      else if (acc_ff < -52'sd2147483648) acc_sat = 32'sh80000000;
      else acc_sat = acc_ff[31:0];
      numer = 33'(signed'(rhs_rd)) - 33'(acc_sat);
      dreq.start = (state_ff == ST_DIAG) && (coef_rd != 32'd0);
      dreq.numer = numer;
      dreq.denom = coef_rd;
      diff = 33'(nxt_ff[i_ff]) - 33'(est_ff[i_ff]);
      adiff = diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(signed'(coef_rd)) * 64'(xj_ff);
      xj_ff <= est_ff[j_ff];
      jd_ff <= j_ff;
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff <= 5'd16;
         tol_ff <= 31'd66;
         iter_ff <= 16'd1000;
         jv_ff <= 1'b0;
         jvd_ff <= 1'b0;
         jv2_ff <= 1'b0;
         sweeps_ff <= '0;
         change_ff <= '0;
         pivot_ff <= 1'b0;
         conv_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               jls_pkg::CSR_SIZE: size_ff <= csr_data[4:0];
               jls_pkg::CSR_TOL: tol_ff <= csr_data[30:0];
               jls_pkg::CSR_ITER: iter_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         jvd_ff <= jv_ff;
         jv2_ff <= jvd_ff && (jd_ff != i_ff);
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_action == jls_pkg::ACT_SOLVE) begin
                  for (int k = 0; k < jls_pkg::MaxSize; k++) est_ff[k] <= '0;
                  sweeps_ff <= '0;
                  change_ff <= '0;
                  pivot_ff <= 1'b0;
                  i_ff <= '0;
                  state_ff <= ST_ROW;
               end
            end
            ST_ROW: begin
               j_ff <= '0;
               acc_ff <= '0;
               jv_ff <= 1'b1;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               if (jv2_ff) acc_ff <= acc_next;
               if (j_ff == last_idx) jv_ff <= 1'b0;
               else if (jv_ff) j_ff <= j_ff + 4'd1;
               if (!jv_ff && !jvd_ff && !jv2_ff) state_ff <= ST_DIAG;
            end
            ST_DIAG: begin
               if (coef_rd == 32'd0) begin
                  nxt_ff[i_ff] <= numer[32] ? 32'sh80000000 : 32'sh7fffffff;
                  pivot_ff <= 1'b1;
                  if (i_ff == last_idx) begin
                     i_ff <= '0;
                     change_ff <= '0;
                     state_ff <= ST_CMP;
                  end else begin
                     i_ff <= i_ff + 4'd1;
                     state_ff <= ST_ROW;
                  end
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (drsp.done) begin
                  nxt_ff[i_ff] <= drsp.quot;
                  if (i_ff == last_idx) begin
                     i_ff <= '0;
                     change_ff <= '0;
                     state_ff <= ST_CMP;
                  end else begin
                     i_ff <= i_ff + 4'd1;
                     state_ff <= ST_ROW;
                  end
               end
            end
            ST_CMP: begin
               est_ff[i_ff] <= nxt_ff[i_ff];
               if (adiff > change_ff) change_ff <= adiff;
               if (i_ff == last_idx) begin
                  i_ff <= '0;
                  sweeps_ff <= sweeps_ff + 16'd1;
                  if ((sweeps_ff + 16'd1) < iter_ff &&
                      ((adiff > change_ff ? adiff : change_ff) >= {1'b0, tol_ff})) begin
                     state_ff <= ST_ROW;
                  end else begin
                     conv_ff <= (adiff > change_ff ? adiff : change_ff) < {1'b0, tol_ff};
                     state_ff <= ST_EMIT;
                  end
               end else begin
                  i_ff <= i_ff + 4'd1;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid || rsp_ready) begin
                  if (rsp_valid && rsp_last) begin
                     rsp_valid <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     rsp_valid <= 1'b1;
                     rsp_index <= i_ff;
                     rsp_solution <= est_ff[i_ff];
                     rsp_last <= (i_ff == last_idx);
                     rsp_sweeps_done <= sweeps_ff;
                     rsp_converged <= conv_ff;
                     rsp_zero_pivot <= pivot_ff;
                     i_ff <= i_ff + 4'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("result shown while accepting requests");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_index)))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (sweeps_ff != 16'd0))
      else $error("emit before any sweep");
endmodule
